// ===== hw/rtl/vargen_pkg.sv =====
// shared types, constants and permutation table for the volume remap address generator
package vargen_pkg;

	localparam int MAX_EXTENT_DEF = 1024;

	localparam int ADDR_W    = 30;
	localparam int SIZE_W    = 11;
	localparam int CODE_W    = 3;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STORE_ORDER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAP    = 3'd4;

	// axis permutation codes
	localparam logic [CODE_W-1:0] PERM_012 = 3'd0;
	localparam logic [CODE_W-1:0] PERM_021 = 3'd1;
	localparam logic [CODE_W-1:0] PERM_102 = 3'd2;
	localparam logic [CODE_W-1:0] PERM_120 = 3'd3;
	localparam logic [CODE_W-1:0] PERM_201 = 3'd4;
	localparam logic [CODE_W-1:0] PERM_210 = 3'd5;

	// element [0] is the first listed axis
	typedef logic [2:0][1:0] axis_row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2
	} state_t;

	typedef struct packed {
		logic accept;
		logic step1;
		logic load;
	} dp_cmd_t;

	function automatic axis_row_t perm_row(input logic [CODE_W-1:0] code);
		axis_row_t row;
		unique case (code)
			PERM_012: row = {2'd2, 2'd1, 2'd0};
			PERM_021: row = {2'd1, 2'd2, 2'd0};
			PERM_102: row = {2'd2, 2'd0, 2'd1};
			PERM_120: row = {2'd0, 2'd2, 2'd1};
			PERM_201: row = {2'd1, 2'd0, 2'd2};
			PERM_210: row = {2'd0, 2'd1, 2'd2};
			// unused codes behave as identity
			default:  row = {2'd2, 2'd1, 2'd0};
		endcase
		return row;
	endfunction

endpackage

// ===== hw/rtl/volume_axis_remap_address_gen_unit.sv =====
// Volume axis remap address generator: each accepted item yields one address pair for the
// next voxel of an x-fastest output volume (source_index, dest_index, last_voxel) and then
// steps the output x/y/z counters, wrapping to the origin after the final voxel; restart
// set on an item returns to the origin first. From acceptance an item passes through the
// states ST_IDLE, ST_MUL1 and ST_MUL2: acceptance captures the permuted coordinates and steps
// the counters, then two dependent multiply-add steps for each index load the output register.
// A new item is accepted once the previous one has reached the output register, so a
// result waiting there does not block the next item; a stalled output holds back the next
// result only when it is still full as that result completes. Configuration writes are taken in
// every cycle and must be made while the block is idle.
module volume_axis_remap_address_gen_unit import vargen_pkg::*; #(
	parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADDR_W-1:0]    source_index,
	output logic [ADDR_W-1:0]    dest_index,
	output logic                 last_voxel,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	vargen_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	vargen_dpath #(
		.MAX_EXTENT (MAX_EXTENT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.restart      (restart),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.source_index (source_index),
		.dest_index   (dest_index),
		.last_voxel   (last_voxel)
	);

endmodule

// ===== hw/rtl/vargen_ctrl.sv =====
// sequencing state machine and output valid flag for the address generator
module vargen_ctrl import vargen_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_MUL1;
				end
			end
			ST_MUL1: state_nxt = ST_MUL2;
			ST_MUL2: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.accept = 1'b0;
		cmd.step1  = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_MUL1: cmd.step1 = 1'b1;
			// result waits here until the output register is free
			ST_MUL2: cmd.load = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/vargen_dpath.sv =====
// configuration registers, output counters and index arithmetic
module vargen_dpath import vargen_pkg::*; #(
	parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic                 restart,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	output logic [ADDR_W-1:0]    source_index,
	output logic [ADDR_W-1:0]    dest_index,
	output logic                 last_voxel
);

	localparam int CNT_W = $clog2(MAX_EXTENT);
	localparam int CMP_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

	logic [2:0][SIZE_W-1:0] size_q;
	logic [CODE_W-1:0]      order_q;
	logic [CODE_W-1:0]      map_q;
	logic [2:0][CNT_W-1:0]  cnt_q;

	logic [2:0][SIZE_W-1:0] dim;
	logic [2:0][SIZE_W-1:0] od;
	logic [2:0][CNT_W-1:0]  o;
	logic [2:0][CNT_W-1:0]  c;
	logic [2:0]             lst;
	logic [2:0][CNT_W-1:0]  cnt_nxt;
	axis_row_t              map_row;
	axis_row_t              ord_row;

	// per-item operands captured at accept
	logic [CNT_W-1:0]  cf_q, cm_q, cs_q;
	logic [SIZE_W-1:0] df_q, dm_q;
	logic [CNT_W-1:0]  ox_q, oy_q, oz_q;
	logic [SIZE_W-1:0] odx_q, ody_q;
	logic              last_q;
	logic [ADDR_W-1:0] t_src_q, t_dst_q;

	logic [SIZE_W+CNT_W-1:0]  prod_src1, prod_dst1;
	logic [SIZE_W+ADDR_W-1:0] prod_src2, prod_dst2;

	function automatic logic [SIZE_W-1:0] clamp_ext(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > MAX_EXTENT) begin
			r = SIZE_W'(MAX_EXTENT);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign map_row = perm_row(map_q);
	assign ord_row = perm_row(order_q);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dim[a] = clamp_ext(size_q[a]);
		end
		for (int i = 0; i < 3; i++) begin
			od[i]  = dim[map_row[i]];
			o[i]   = restart ? '0 : cnt_q[i];
			lst[i] = (CMP_W'(o[i]) + CMP_W'(1)) >= CMP_W'(od[i]);
		end
		// coordinate along each source axis
		for (int a = 0; a < 3; a++) begin
			if (map_row[0] == 2'(a)) begin
				c[a] = o[0];
			end else if (map_row[1] == 2'(a)) begin
				c[a] = o[1];
			end else begin
				c[a] = o[2];
			end
		end
	end

	// x fastest, then y, then z; a stale counter beyond its extent wraps
	always_comb begin
		cnt_nxt = cnt_q;
		if (!lst[0]) begin
			cnt_nxt[0] = o[0] + CNT_W'(1);
			cnt_nxt[1] = o[1];
			cnt_nxt[2] = o[2];
		end else begin
			cnt_nxt[0] = '0;
			if (!lst[1]) begin
				cnt_nxt[1] = o[1] + CNT_W'(1);
				cnt_nxt[2] = o[2];
			end else begin
				cnt_nxt[1] = '0;
				cnt_nxt[2] = lst[2] ? '0 : o[2] + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= SIZE_W'(1);
			size_q[1] <= SIZE_W'(1);
			size_q[2] <= SIZE_W'(1);
			order_q   <= PERM_210;
			map_q     <= PERM_012;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SIZE_X:      size_q[0] <= cfg_data;
					CFG_SIZE_Y:      size_q[1] <= cfg_data;
					CFG_SIZE_Z:      size_q[2] <= cfg_data;
					CFG_STORE_ORDER: order_q   <= cfg_data[CODE_W-1:0];
					CFG_AXIS_MAP:    map_q     <= cfg_data[CODE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	assign prod_src1 = dm_q * cs_q;
	assign prod_dst1 = ody_q * oz_q;
	assign prod_src2 = df_q * t_src_q;
	assign prod_dst2 = odx_q * t_dst_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cf_q   <= c[ord_row[0]];
			cm_q   <= c[ord_row[1]];
			cs_q   <= c[ord_row[2]];
			df_q   <= dim[ord_row[0]];
			dm_q   <= dim[ord_row[1]];
			ox_q   <= o[0];
			oy_q   <= o[1];
			oz_q   <= o[2];
			odx_q  <= od[0];
			ody_q  <= od[1];
			last_q <= &lst;
		end
		// inner terms: mid + dmid*slow and oz*dy + oy
		if (cmd.step1) begin
			t_src_q <= ADDR_W'(cm_q) + ADDR_W'(prod_src1);
			t_dst_q <= ADDR_W'(oy_q) + ADDR_W'(prod_dst1);
		end
		if (cmd.load) begin
			source_index <= ADDR_W'(cf_q) + ADDR_W'(prod_src2);
			dest_index   <= ADDR_W'(ox_q) + ADDR_W'(prod_dst2);
			last_voxel   <= last_q;
		end
	end

endmodule

// ===== hw/rtl/vargen_checker.sv =====
// port-level assertions for the address generator, bound to the top level
module vargen_checker import vargen_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              restart,
	input logic              out_valid,
	input logic              out_stall,
	input logic [ADDR_W-1:0] source_index,
	input logic [ADDR_W-1:0] dest_index,
	input logic              last_voxel
);

	// one item in flight: no acceptance while the item is in ST_MUL1 and ST_MUL2
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall ##1 in_stall)
		else $error("item accepted while previous item still computing");

	// a fresh result follows an accepted item that went straight through ST_MUL1 and ST_MUL2
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 3))
		else $error("result appeared without matching item");

	// restart item addresses the origin of both volumes
	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && $past(in_valid && !in_stall && restart, 3))
		|-> (source_index == '0) && (dest_index == '0))
		else $error("restart item did not address the origin");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(source_index)
		&& $stable(dest_index) && $stable(last_voxel))
		else $error("stalled result changed");

endmodule

bind volume_axis_remap_address_gen_unit vargen_checker u_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the volume axis remap address generator
module tb;
	import vargen_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int RANDOM_ITEMS  = 1350;
	localparam int SETTLE_CYCLES = 8;

	// codes past the six permutations
	localparam logic [CODE_W-1:0] PERM_SPARE_6 = 3'd6;
	localparam logic [CODE_W-1:0] PERM_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic              last;
	} voxel_addr_t;

	class remap_checker;
		logic [SIZE_W-1:0] extent_reg [3];
		logic [CODE_W-1:0] order_reg;
		logic [CODE_W-1:0] map_reg;
		int unsigned       out_pos [3];
		voxel_addr_t       pending_addrs [$];
		int                errors;
		int                checked;
		int                last_seen;

		function new();
			extent_reg = '{default: SIZE_W'(1)};
			order_reg  = PERM_210;
			map_reg    = PERM_012;
			out_pos    = '{default: 0};
			errors     = 0;
			checked    = 0;
			last_seen  = 0;
		endfunction

		// [0] is the first listed axis: first = code / 2, the other two ascending, swapped if odd
		function axis_row_t axes_of(input logic [CODE_W-1:0] code);
			axis_row_t        a;
			logic [CODE_W-1:0] c;
			logic [1:0]       lo;
			logic [1:0]       hi;
			c = (code > PERM_210) ? PERM_012 : code;
			a[0] = c[2:1];
			lo = (a[0] == 2'd0) ? 2'd1 : 2'd0;
			hi = (a[0] == 2'd2) ? 2'd1 : 2'd2;
			a[1] = c[0] ? hi : lo;
			a[2] = c[0] ? lo : hi;
			return a;
		endfunction

		function longint unsigned clamp(input logic [SIZE_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_EXTENT_DEF)
				return MAX_EXTENT_DEF;
			return v;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
			case (idx)
				CFG_SIZE_X:      extent_reg[0] = data;
				CFG_SIZE_Y:      extent_reg[1] = data;
				CFG_SIZE_Z:      extent_reg[2] = data;
				CFG_STORE_ORDER: order_reg = data[CODE_W-1:0];
				CFG_AXIS_MAP:    map_reg = data[CODE_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_voxel(input logic rst);
			longint unsigned dims [3];
			longint unsigned od [3];
			longint unsigned c [3];
			longint unsigned src;
			longint unsigned dst;
			axis_row_t       mp;
			axis_row_t       ord;
			logic            lx;
			logic            ly;
			logic            lz;
			if (rst)
				out_pos = '{default: 0};
			mp  = axes_of(map_reg);
			ord = axes_of(order_reg);
			for (int i = 0; i < 3; i++)
				dims[i] = clamp(extent_reg[i]);
			for (int i = 0; i < 3; i++) begin
				od[i]    = dims[mp[i]];
				c[mp[i]] = out_pos[i];
			end
			src = c[ord[0]] + dims[ord[0]] * (c[ord[1]] + dims[ord[1]] * c[ord[2]]);
			dst = (longint'(out_pos[2]) * od[1] + out_pos[1]) * od[0] + out_pos[0];
			// a stale counter past its extent counts as the last position
			lx = longint'(out_pos[0]) + 1 >= od[0];
			ly = longint'(out_pos[1]) + 1 >= od[1];
			lz = longint'(out_pos[2]) + 1 >= od[2];
			pending_addrs.push_back('{src: src[ADDR_W-1:0], dst: dst[ADDR_W-1:0],
				last: lx && ly && lz});
			if (!lx) begin
				out_pos[0]++;
			end else begin
				out_pos[0] = 0;
				if (!ly) begin
					out_pos[1]++;
				end else begin
					out_pos[1] = 0;
					out_pos[2] = lz ? 0 : out_pos[2] + 1;
				end
			end
		endfunction

		function void match_result(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
			input logic last);
			voxel_addr_t e;
			if (pending_addrs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: source_index %0h dest_index %0h last_voxel %0b",
					$time, src, dst, last);
				return;
			end
			e = pending_addrs.pop_front();
			checked++;
			if (last === 1'b1)
				last_seen++;
			if (src !== e.src) begin
				errors++;
				$display("%0t: source_index mismatch: expected %0h, actual %0h", $time, e.src, src);
			end
			if (dst !== e.dst) begin
				errors++;
				$display("%0t: dest_index mismatch: expected %0h, actual %0h", $time, e.dst, dst);
			end
			if (last !== e.last) begin
				errors++;
				$display("%0t: last_voxel mismatch: expected %0b, actual %0b", $time, e.last, last);
			end
		endfunction

		function int pending();
			return pending_addrs.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 restart;
	logic                 out_valid;
	logic                 out_stall;
	logic [ADDR_W-1:0]    source_index;
	logic [ADDR_W-1:0]    dest_index;
	logic                 last_voxel;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	remap_checker sb = new();
	int           tx_idle_pct = 0;
	int           rx_stall_pct = 0;
	int           cycles = 0;
	int           items_sent = 0;

	volume_axis_remap_address_gen_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.source_index (source_index),
		.dest_index   (dest_index),
		.last_voxel   (last_voxel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// handshakes are sampled with the values from before the edge
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
		if (arst_n && in_valid && !in_stall)
			sb.take_voxel(restart);
		if (arst_n && out_valid && !out_stall)
			sb.match_result(source_index, dest_index, last_voxel);
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic send_item(input logic rst);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// leaves valid high so that writes can go back to back
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic drain();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SIZE_W-1:0] pick_extent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return SIZE_W'($urandom_range(1, 6));
		if (r < 75)
			return SIZE_W'($urandom_range(7, 40));
		if (r < 80)
			return '0;
		if (r < 85)
			return SIZE_W'(MAX_EXTENT_DEF);
		if (r < 90)
			return SIZE_W'($urandom_range(MAX_EXTENT_DEF + 1, (1 << SIZE_W) - 1));
		return SIZE_W'($urandom_range(1, MAX_EXTENT_DEF));
	endfunction

	// random upper bits ride along with the code
	function automatic logic [SIZE_W-1:0] code_word(input logic [CODE_W-1:0] code);
		logic [SIZE_W-1:0] w;
		w = SIZE_W'($urandom);
		w[CODE_W-1:0] = code;
		return w;
	endfunction

	initial begin
		int phase;
		int sent;
		int n;
		int hold_at;
		int directed;
		in_valid  = 1'b0;
		restart   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SIZE_X;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1x1x1 volume, every item is the last voxel
		send_item(1'b0);
		send_item(1'b1);
		drain();

		// clamped extents, spare codes, writes past the register map
		cfg_write(CFG_SIZE_X, SIZE_W'(MAX_EXTENT_DEF));
		cfg_write(CFG_SIZE_Y, '1);
		cfg_write(CFG_SIZE_Z, '0);
		cfg_write(CFG_STORE_ORDER, code_word(PERM_SPARE_7));
		cfg_write(CFG_AXIS_MAP, code_word(PERM_SPARE_6));
		for (int k = CFG_AXIS_MAP + 1; k < (1 << CFG_IDX_W); k++)
			cfg_write(CFG_IDX_W'(k), '1);
		cfg_close();
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
		drain();

		// shrink x under a running counter so the stale value gets used
		cfg_write(CFG_SIZE_X, SIZE_W'(8));
		cfg_write(CFG_SIZE_Y, SIZE_W'(3));
		cfg_write(CFG_SIZE_Z, SIZE_W'(2));
		cfg_write(CFG_STORE_ORDER, code_word(PERM_012));
		cfg_write(CFG_AXIS_MAP, code_word(PERM_012));
		cfg_close();
		send_item(1'b1);
		repeat (5) send_item(1'b0);
		drain();
		cfg_write(CFG_SIZE_X, SIZE_W'(2));
		cfg_close();
		repeat (3) send_item(1'b0);
		drain();

		// every order and map code on an uneven volume
		cfg_write(CFG_SIZE_Y, SIZE_W'(3));
		cfg_write(CFG_SIZE_Z, SIZE_W'(4));
		for (int k = 0; k < (1 << CODE_W); k++) begin
			cfg_write(CFG_STORE_ORDER, code_word(CODE_W'(k)));
			cfg_write(CFG_AXIS_MAP, code_word(CODE_W'((1 << CODE_W) - 1 - k)));
			cfg_close();
			send_item(1'b0);
			drain();
		end
		directed = items_sent;

		phase = 0;
		sent  = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
				default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
			endcase
			if ($urandom_range(0, 3) != 0)
				cfg_write(CFG_SIZE_X, pick_extent());
			if ($urandom_range(0, 3) != 0)
				cfg_write(CFG_SIZE_Y, pick_extent());
			if ($urandom_range(0, 3) != 0)
				cfg_write(CFG_SIZE_Z, pick_extent());
			if ($urandom_range(0, 2) != 0)
				cfg_write(CFG_STORE_ORDER, code_word(CODE_W'($urandom_range(0, 7))));
			if ($urandom_range(0, 2) != 0)
				cfg_write(CFG_AXIS_MAP, code_word(CODE_W'($urandom_range(0, 7))));
			if ($urandom_range(0, 7) == 0)
				cfg_write(CFG_IDX_W'($urandom_range(CFG_AXIS_MAP + 1, (1 << CFG_IDX_W) - 1)),
					SIZE_W'($urandom));
			cfg_close();
			n = $urandom_range(50, 150);
			hold_at = $urandom_range(1, n - 1);
			for (int i = 0; i < n; i++) begin
				// sender holds off until the pipeline is empty
				if (i == hold_at)
					wait_results();
				// long runs without restart so the counters wrap through whole volumes
				send_item((i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0));
			end
			sent += n;
			phase++;
			drain();
		end

		drain();
		$display("covered %0d directed and %0d random items over %0d random settings",
			directed, sent, phase);
		$display("%0d results checked, %0d of them final voxels, %0d errors",
			sb.checked, sb.last_seen, sb.errors);
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
